[rtl/tdd_pkg.sv]
// ----------------------------------------------------------------------------
// tdd_pkg
// Shared types and constants for the typed descriptor deque.
// ----------------------------------------------------------------------------
package tdd_pkg;

    localparam int HANDLE_W       = 6;
    localparam int TYPE_W         = 3;
    localparam int CMD_W          = 3;
    localparam int CNT_W          = 7;
    localparam int ERR_W          = 3;
    localparam int DEF_POOL_DEPTH = 64;
    localparam int DEF_TYPE_COUNT = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CMD_W-1:0] CMD_PUT_HEAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT_TAIL  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE_HEAD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAKE_TAIL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd6;

    localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY      = 3'd1;
    localparam logic [ERR_W-1:0] ERR_QUEUED     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NOT_QUEUED = 3'd3;
    localparam logic [ERR_W-1:0] ERR_RANGE      = 3'd4;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_TAKE,
        OP_REMOVE,
        OP_PEEK,
        OP_COUNT,
        OP_NOP,
        OP_RANGE
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic                at_head;
        logic [HANDLE_W-1:0] handle;
        logic [TYPE_W-1:0]   put_type;
        logic [TYPE_W-1:0]   query_type;
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LINK,
        ST_UNLINK,
        ST_TYPE,
        ST_EMIT
    } state_t;

endpackage

[rtl/typed_descriptor_deque_unit.sv]
// ----------------------------------------------------------------------------
// typed_descriptor_deque_unit
// Deque of descriptor handles kept as a circular doubly linked list, with
// per-type counts.
// ----------------------------------------------------------------------------
// Channel | Handshake        | Payload
// input   | in_valid/stall   | command, handle, desc_type
// output  | out_valid/stall  | handle_out .. error_code
//
// In the back end, peek, count and empty take go straight to the result;
// puts and removes read the entry flag first, then one or two link
// writes through the single write port of each link store, then a type read
// when an unlink moves the head or tail. After reset a clearing pass runs
// over the queued flags; in_stall is high meanwhile. A stalled result
// holds in the output register; up to two items wait in the queue.
// ----------------------------------------------------------------------------
module typed_descriptor_deque_unit #(
    parameter int POOL_DEPTH = tdd_pkg::DEF_POOL_DEPTH,
    parameter int TYPE_COUNT = tdd_pkg::DEF_TYPE_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tdd_pkg::CMD_W-1:0]     command,
    input  logic [tdd_pkg::HANDLE_W-1:0]  handle,
    input  logic [tdd_pkg::TYPE_W-1:0]    desc_type,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tdd_pkg::HANDLE_W-1:0]  handle_out,
    output logic [tdd_pkg::TYPE_W-1:0]    type_out,
    output logic [tdd_pkg::TYPE_W-1:0]    tail_type,
    output logic                          head_match,
    output logic                          tail_match,
    output logic                          valid_out,
    output logic [tdd_pkg::CNT_W-1:0]     occupancy,
    output logic [tdd_pkg::CNT_W-1:0]     type_total,
    output logic [tdd_pkg::ERR_W-1:0]     error_code
);

    logic         q_full, clearing, push, pop, not_empty;
    tdd_pkg::op_t push_op, pop_op;

    tdd_front #(
        .POOL_DEPTH (POOL_DEPTH),
        .TYPE_COUNT (TYPE_COUNT)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .handle    (handle),
        .desc_type (desc_type),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .push_op   (push_op)
    );

    tdd_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_op    (pop_op)
    );

    tdd_back #(
        .POOL_DEPTH (POOL_DEPTH),
        .TYPE_COUNT (TYPE_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (not_empty),
        .op         (pop_op),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .handle_out (handle_out),
        .type_out   (type_out),
        .tail_type  (tail_type),
        .head_match (head_match),
        .tail_match (tail_match),
        .valid_out  (valid_out),
        .occupancy  (occupancy),
        .type_total (type_total),
        .error_code (error_code)
    );

endmodule

[rtl/tdd_front.sv]
// ----------------------------------------------------------------------------
// tdd_front
// Accepts input items, decodes and range checks them into operations.
// ----------------------------------------------------------------------------
module tdd_front #(
    parameter int POOL_DEPTH = tdd_pkg::DEF_POOL_DEPTH,
    parameter int TYPE_COUNT = tdd_pkg::DEF_TYPE_COUNT
) (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tdd_pkg::CMD_W-1:0]     command,
    input  logic [tdd_pkg::HANDLE_W-1:0]  handle,
    input  logic [tdd_pkg::TYPE_W-1:0]    desc_type,
    input  logic                          q_full,
    input  logic                          clearing,
    output logic                          push,
    output tdd_pkg::op_t                  push_op
);

    localparam logic [tdd_pkg::TYPE_W-1:0] NONE_TYPE = tdd_pkg::TYPE_W'(TYPE_COUNT);

    logic in_pool;

    assign in_stall = q_full || clearing;
    assign push     = in_valid && !in_stall;
    assign in_pool  = 32'(handle) < POOL_DEPTH;

    always_comb
    begin
        push_op.handle     = handle;
        push_op.query_type = desc_type;
        push_op.put_type   = (desc_type > NONE_TYPE) ? NONE_TYPE : desc_type;
        push_op.at_head    = 1'b0;
        unique case (command)
            tdd_pkg::CMD_PUT_HEAD:
            begin
                push_op.kind    = in_pool ? tdd_pkg::OP_PUT : tdd_pkg::OP_RANGE;
                push_op.at_head = 1'b1;
            end
            tdd_pkg::CMD_PUT_TAIL:
                push_op.kind = in_pool ? tdd_pkg::OP_PUT : tdd_pkg::OP_RANGE;
            tdd_pkg::CMD_TAKE_HEAD:
            begin
                push_op.kind    = tdd_pkg::OP_TAKE;
                push_op.at_head = 1'b1;
            end
            tdd_pkg::CMD_TAKE_TAIL:
                push_op.kind = tdd_pkg::OP_TAKE;
            tdd_pkg::CMD_REMOVE:
                push_op.kind = in_pool ? tdd_pkg::OP_REMOVE : tdd_pkg::OP_RANGE;
            tdd_pkg::CMD_PEEK:
                push_op.kind = tdd_pkg::OP_PEEK;
            tdd_pkg::CMD_COUNT:
                push_op.kind = tdd_pkg::OP_COUNT;
            default:
                push_op.kind = tdd_pkg::OP_NOP;
        endcase
    end

endmodule

[rtl/tdd_cmdq.sv]
// ----------------------------------------------------------------------------
// tdd_cmdq
// Short queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module tdd_cmdq (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  tdd_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output tdd_pkg::op_t pop_op
);

    localparam int PW = (tdd_pkg::QUEUE_DEPTH > 1) ? $clog2(tdd_pkg::QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(tdd_pkg::QUEUE_DEPTH + 1);

    tdd_pkg::op_t  slot_reg [tdd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [FW-1:0] fill_reg, fill_next;

    assign full      = fill_reg == FW'(tdd_pkg::QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign pop_op    = slot_reg[rd_reg];

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(tdd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(tdd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_op;
        end
    end

endmodule

[rtl/tdd_back.sv]
// ----------------------------------------------------------------------------
// tdd_back
// Executes operations on the linked ring and drives the result register.
// ----------------------------------------------------------------------------
module tdd_back #(
    parameter int POOL_DEPTH = tdd_pkg::DEF_POOL_DEPTH,
    parameter int TYPE_COUNT = tdd_pkg::DEF_TYPE_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  tdd_pkg::op_t                  op,
    output logic                          pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tdd_pkg::HANDLE_W-1:0]  handle_out,
    output logic [tdd_pkg::TYPE_W-1:0]    type_out,
    output logic [tdd_pkg::TYPE_W-1:0]    tail_type,
    output logic                          head_match,
    output logic                          tail_match,
    output logic                          valid_out,
    output logic [tdd_pkg::CNT_W-1:0]     occupancy,
    output logic [tdd_pkg::CNT_W-1:0]     type_total,
    output logic [tdd_pkg::ERR_W-1:0]     error_code
);

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int SW = $clog2(POOL_DEPTH + 1);
    localparam int TW = tdd_pkg::TYPE_W;
    localparam int EW = tdd_pkg::ERR_W;
    localparam logic [TW-1:0] NONE_TYPE = TW'(TYPE_COUNT);

    // link stores
    logic [AW-1:0] nxt_mem [POOL_DEPTH];
    logic [AW-1:0] prv_mem [POOL_DEPTH];
    logic [TW-1:0] typ_mem [POOL_DEPTH];
    logic          q_mem   [POOL_DEPTH];

    logic [AW-1:0] nxt_rd_reg, prv_rd_reg;
    logic [TW-1:0] typ_rd_reg;
    logic          q_rd_reg;

    tdd_pkg::state_t state_reg, state_next;
    tdd_pkg::op_t    op_reg, op_next;
    logic [AW-1:0]   e_reg, e_next;
    logic [TW-1:0]   te_reg, te_next;
    logic [EW-1:0]   err_reg, err_next;
    logic            took_reg, took_next;
    logic            fix_head_reg, fix_head_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [TW-1:0]   htype_reg, htype_next;
    logic [TW-1:0]   ttype_reg, ttype_next;
    logic [SW-1:0]   size_reg, size_next;
    logic [SW-1:0]   counts_reg [TYPE_COUNT];
    logic [SW-1:0]   counts_next [TYPE_COUNT];
    logic [AW-1:0]   clr_reg, clr_next;

    logic          link_re, q_re, typ_re;
    logic [AW-1:0] link_raddr, q_raddr, typ_raddr;
    logic          nxt_we, prv_we, typ_we, q_we;
    logic [AW-1:0] nxt_waddr, prv_waddr, typ_waddr, q_waddr;
    logic [AW-1:0] nxt_wdata, prv_wdata;
    logic [TW-1:0] typ_wdata;
    logic          q_wdata;
    logic          cnt_inc, cnt_dec;
    logic [TW-1:0] cnt_type;
    logic          load_out;

    logic [tdd_pkg::HANDLE_W-1:0] hout_reg;
    logic [TW-1:0]                tout_reg, ttail_reg;
    logic                         hmatch_reg, tmatch_reg, vout_reg, out_valid_reg;
    logic [tdd_pkg::CNT_W-1:0]    occ_reg, total_reg;
    logic [EW-1:0]                ecode_reg;

    logic [AW-1:0] op_idx;
    logic [AW-1:0] take_idx;
    logic [tdd_pkg::CNT_W-1:0] total_sel;

    assign op_idx   = AW'(op.handle);
    assign take_idx = op.at_head ? head_reg : tail_reg;
    assign clearing = state_reg == tdd_pkg::ST_CLEAR;

    always_comb
    begin
        total_sel = '0;
        for (int i = 0; i < TYPE_COUNT; i++)
        begin
            if (32'(op_reg.query_type) == i)
            begin
                total_sel = tdd_pkg::CNT_W'(counts_reg[i]);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        e_next        = e_reg;
        te_next       = te_reg;
        err_next      = err_reg;
        took_next     = took_reg;
        fix_head_next = fix_head_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        htype_next    = htype_reg;
        ttype_next    = ttype_reg;
        size_next     = size_reg;
        clr_next      = clr_reg;
        pop           = 1'b0;
        link_re       = 1'b0;
        q_re          = 1'b0;
        typ_re        = 1'b0;
        link_raddr    = op_idx;
        q_raddr       = op_idx;
        typ_raddr     = op_idx;
        nxt_we        = 1'b0;
        prv_we        = 1'b0;
        typ_we        = 1'b0;
        q_we          = 1'b0;
        nxt_waddr     = '0;
        prv_waddr     = '0;
        typ_waddr     = '0;
        q_waddr       = '0;
        nxt_wdata     = '0;
        prv_wdata     = '0;
        typ_wdata     = '0;
        q_wdata       = 1'b0;
        cnt_inc       = 1'b0;
        cnt_dec       = 1'b0;
        cnt_type      = '0;
        load_out      = 1'b0;

        unique case (state_reg)
            tdd_pkg::ST_CLEAR:
            begin
                q_we     = 1'b1;
                q_waddr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(POOL_DEPTH - 1))
                begin
                    state_next = tdd_pkg::ST_IDLE;
                end
            end
            tdd_pkg::ST_IDLE:
            begin
                if (op_valid)
                begin
                    pop        = 1'b1;
                    op_next    = op;
                    err_next   = tdd_pkg::ERR_OK;
                    took_next  = 1'b0;
                    q_re       = 1'b1;
                    typ_re     = 1'b1;
                    link_re    = 1'b1;
                    state_next = tdd_pkg::ST_EMIT;
                    unique case (op.kind)
                        tdd_pkg::OP_PUT, tdd_pkg::OP_REMOVE:
                            state_next = tdd_pkg::ST_CHECK;
                        tdd_pkg::OP_TAKE:
                        begin
                            link_raddr = take_idx;
                            if (size_reg == '0)
                            begin
                                err_next = tdd_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                e_next    = take_idx;
                                te_next   = op.at_head ? htype_reg : ttype_reg;
                                took_next = 1'b1;
                                if (size_reg == SW'(1))
                                begin
                                    q_we       = 1'b1;
                                    q_waddr    = take_idx;
                                    size_next  = '0;
                                    head_next  = '0;
                                    htype_next = NONE_TYPE;
                                    ttype_next = NONE_TYPE;
                                    cnt_dec    = 1'b1;
                                    cnt_type   = htype_reg;
                                end
                                else
                                begin
                                    state_next = tdd_pkg::ST_UNLINK;
                                end
                            end
                        end
                        tdd_pkg::OP_RANGE:
                            err_next = tdd_pkg::ERR_RANGE;
                        tdd_pkg::OP_COUNT:
                            if (32'(op.query_type) >= TYPE_COUNT)
                            begin
                                err_next = tdd_pkg::ERR_RANGE;
                            end
                        default:
                            err_next = tdd_pkg::ERR_OK;
                    endcase
                end
            end
            tdd_pkg::ST_CHECK:
            begin
                state_next = tdd_pkg::ST_EMIT;
                if (op_reg.kind == tdd_pkg::OP_PUT)
                begin
                    if (q_rd_reg)
                    begin
                        err_next = tdd_pkg::ERR_QUEUED;
                    end
                    else
                    begin
                        q_we      = 1'b1;
                        q_waddr   = AW'(op_reg.handle);
                        q_wdata   = 1'b1;
                        typ_we    = 1'b1;
                        typ_waddr = AW'(op_reg.handle);
                        typ_wdata = op_reg.put_type;
                        cnt_inc   = 1'b1;
                        cnt_type  = op_reg.put_type;
                        size_next = size_reg + 1'b1;
                        nxt_we    = 1'b1;
                        prv_we    = 1'b1;
                        nxt_waddr = AW'(op_reg.handle);
                        prv_waddr = AW'(op_reg.handle);
                        if (size_reg == '0)
                        begin
                            nxt_wdata  = AW'(op_reg.handle);
                            prv_wdata  = AW'(op_reg.handle);
                            head_next  = AW'(op_reg.handle);
                            tail_next  = AW'(op_reg.handle);
                            htype_next = op_reg.put_type;
                            ttype_next = op_reg.put_type;
                        end
                        else
                        begin
                            nxt_wdata  = head_reg;
                            prv_wdata  = tail_reg;
                            state_next = tdd_pkg::ST_LINK;
                        end
                    end
                end
                else
                begin
                    if (!q_rd_reg)
                    begin
                        err_next = tdd_pkg::ERR_NOT_QUEUED;
                    end
                    else
                    begin
                        e_next  = AW'(op_reg.handle);
                        te_next = typ_rd_reg;
                        if (size_reg == SW'(1))
                        begin
                            q_we       = 1'b1;
                            q_waddr    = AW'(op_reg.handle);
                            size_next  = '0;
                            head_next  = '0;
                            htype_next = NONE_TYPE;
                            ttype_next = NONE_TYPE;
                            cnt_dec    = 1'b1;
                            cnt_type   = typ_rd_reg;
                        end
                        else
                        begin
                            state_next = tdd_pkg::ST_UNLINK;
                        end
                    end
                end
            end
            tdd_pkg::ST_LINK:
            begin
                prv_we    = 1'b1;
                prv_waddr = head_reg;
                prv_wdata = AW'(op_reg.handle);
                nxt_we    = 1'b1;
                nxt_waddr = tail_reg;
                nxt_wdata = AW'(op_reg.handle);
                if (op_reg.at_head)
                begin
                    head_next  = AW'(op_reg.handle);
                    htype_next = op_reg.put_type;
                end
                else
                begin
                    tail_next  = AW'(op_reg.handle);
                    ttype_next = op_reg.put_type;
                end
                state_next = tdd_pkg::ST_EMIT;
            end
            tdd_pkg::ST_UNLINK:
            begin
                prv_we     = 1'b1;
                prv_waddr  = nxt_rd_reg;
                prv_wdata  = prv_rd_reg;
                nxt_we     = 1'b1;
                nxt_waddr  = prv_rd_reg;
                nxt_wdata  = nxt_rd_reg;
                q_we       = 1'b1;
                q_waddr    = e_reg;
                size_next  = size_reg - 1'b1;
                cnt_dec    = 1'b1;
                cnt_type   = te_reg;
                state_next = tdd_pkg::ST_EMIT;
                if (head_reg == e_reg)
                begin
                    head_next     = nxt_rd_reg;
                    typ_re        = 1'b1;
                    typ_raddr     = nxt_rd_reg;
                    fix_head_next = 1'b1;
                    state_next    = tdd_pkg::ST_TYPE;
                end
                else if (tail_reg == e_reg)
                begin
                    tail_next     = prv_rd_reg;
                    typ_re        = 1'b1;
                    typ_raddr     = prv_rd_reg;
                    fix_head_next = 1'b0;
                    state_next    = tdd_pkg::ST_TYPE;
                end
            end
            tdd_pkg::ST_TYPE:
            begin
                if (fix_head_reg)
                begin
                    htype_next = typ_rd_reg;
                end
                else
                begin
                    ttype_next = typ_rd_reg;
                end
                state_next = tdd_pkg::ST_EMIT;
            end
            tdd_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = tdd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tdd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < TYPE_COUNT; i++)
        begin
            counts_next[i] = counts_reg[i];
            if (32'(cnt_type) == i)
            begin
                if (cnt_inc)
                begin
                    counts_next[i] = counts_reg[i] + 1'b1;
                end
                else if (cnt_dec && counts_reg[i] != '0)
                begin
                    counts_next[i] = counts_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdd_pkg::ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            htype_reg     <= NONE_TYPE;
            ttype_reg     <= NONE_TYPE;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TYPE_COUNT; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            htype_reg <= htype_next;
            ttype_reg <= ttype_next;
            size_reg  <= size_next;
            for (int i = 0; i < TYPE_COUNT; i++)
            begin
                counts_reg[i] <= counts_next[i];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        e_reg        <= e_next;
        te_reg       <= te_next;
        err_reg      <= err_next;
        took_reg     <= took_next;
        fix_head_reg <= fix_head_next;
        if (load_out)
        begin
            hout_reg   <= took_reg ? tdd_pkg::HANDLE_W'(e_reg)
                        : (op_reg.kind == tdd_pkg::OP_PEEK && size_reg != '0)
                          ? tdd_pkg::HANDLE_W'(head_reg) : '0;
            vout_reg   <= took_reg || (op_reg.kind == tdd_pkg::OP_PEEK && size_reg != '0);
            tout_reg   <= took_reg ? te_reg : htype_reg;
            ttail_reg  <= ttype_reg;
            hmatch_reg <= (size_reg != '0) && (htype_reg == op_reg.query_type);
            tmatch_reg <= (size_reg != '0) && (ttype_reg == op_reg.query_type);
            occ_reg    <= tdd_pkg::CNT_W'(size_reg);
            total_reg  <= (op_reg.kind == tdd_pkg::OP_COUNT) ? total_sel : '0;
            ecode_reg  <= err_reg;
        end
    end

    // memories: registered reads, one write port each
    always_ff @(posedge clk)
    begin
        if (link_re)
        begin
            nxt_rd_reg <= nxt_mem[link_raddr];
            prv_rd_reg <= prv_mem[link_raddr];
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (prv_we)
        begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (typ_re)
        begin
            typ_rd_reg <= typ_mem[typ_raddr];
        end
        if (typ_we)
        begin
            typ_mem[typ_waddr] <= typ_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_re)
        begin
            q_rd_reg <= q_mem[q_raddr];
        end
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
    end

    assign out_valid  = out_valid_reg;
    assign handle_out = hout_reg;
    assign type_out   = tout_reg;
    assign tail_type  = ttail_reg;
    assign head_match = hmatch_reg;
    assign tail_match = tmatch_reg;
    assign valid_out  = vout_reg;
    assign occupancy  = occ_reg;
    assign type_total = total_reg;
    assign error_code = ecode_reg;

endmodule

[tb/typed_descriptor_deque_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_descriptor_deque_unit_tb
// Drives deque commands through the input channel with random gaps and
// checks every result against a behavioural deque kept in the bench.
// ----------------------------------------------------------------------------
module typed_descriptor_deque_unit_tb;

    localparam int POOL  = tdd_pkg::DEF_POOL_DEPTH;
    localparam int NTYPE = tdd_pkg::DEF_TYPE_COUNT;
    localparam int CMD_UNUSED = 7;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [tdd_pkg::CMD_W-1:0]    cmd;
        logic [tdd_pkg::HANDLE_W-1:0] hnd;
        logic [tdd_pkg::TYPE_W-1:0]   dtype;
    } deque_cmd_t;

    typedef struct packed {
        logic [tdd_pkg::HANDLE_W-1:0] hnd;
        logic [tdd_pkg::TYPE_W-1:0]   ty;
        logic [tdd_pkg::TYPE_W-1:0]   tail_ty;
        logic                         hmatch;
        logic                         tmatch;
        logic                         vld;
        logic [tdd_pkg::CNT_W-1:0]    occ;
        logic [tdd_pkg::CNT_W-1:0]    total;
        logic [tdd_pkg::ERR_W-1:0]    err;
    } deque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [tdd_pkg::CMD_W-1:0] command = '0;
    logic [tdd_pkg::HANDLE_W-1:0] handle = '0;
    logic [tdd_pkg::TYPE_W-1:0] desc_type = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [tdd_pkg::HANDLE_W-1:0] handle_out;
    logic [tdd_pkg::TYPE_W-1:0] type_out, tail_type;
    logic head_match, tail_match, valid_out;
    logic [tdd_pkg::CNT_W-1:0] occupancy, type_total;
    logic [tdd_pkg::ERR_W-1:0] error_code;

    typed_descriptor_deque_unit i_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // bench copy of the deque
    logic [tdd_pkg::HANDLE_W-1:0] nxt [POOL];
    logic [tdd_pkg::HANDLE_W-1:0] prv [POOL];
    logic [tdd_pkg::TYPE_W-1:0]   ety [POOL];
    bit                           on_q [POOL];
    logic [tdd_pkg::HANDLE_W-1:0] head_h;
    int                           qsize;
    int                           tcount [NTYPE];

    deque_cmd_t    pending_cmds [$];
    deque_result_t expected_results [$];
    int  failures = 0;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;
    longint cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_put();
        return $urandom_range(0, 1) ? int'(tdd_pkg::CMD_PUT_HEAD) : int'(tdd_pkg::CMD_PUT_TAIL);
    endfunction

    function automatic int pick_take();
        return $urandom_range(0, 1) ? int'(tdd_pkg::CMD_TAKE_HEAD)
                                    : int'(tdd_pkg::CMD_TAKE_TAIL);
    endfunction

    function automatic void detach(logic [tdd_pkg::HANDLE_W-1:0] h);
        if (qsize <= 1)
            head_h = '0;
        else
        begin
            prv[nxt[h]] = prv[h];
            nxt[prv[h]] = nxt[h];
            if (head_h == h)
                head_h = nxt[h];
        end
        qsize--;
        if (ety[h] < NTYPE && tcount[ety[h]] > 0)
            tcount[ety[h]]--;
        on_q[h] = 1'b0;
    endfunction

    function automatic void attach(logic [tdd_pkg::HANDLE_W-1:0] h,
                                   logic [tdd_pkg::TYPE_W-1:0] t, bit at_head);
        logic [tdd_pkg::HANDLE_W-1:0] tl;
        if (qsize == 0)
        begin
            nxt[h] = h;
            prv[h] = h;
            head_h = h;
        end
        else
        begin
            tl = prv[head_h];
            nxt[h] = head_h;
            prv[h] = tl;
            prv[head_h] = h;
            nxt[tl] = h;
            if (at_head)
                head_h = h;
        end
        ety[h] = t;
        on_q[h] = 1'b1;
        qsize++;
        if (t < NTYPE)
            tcount[t]++;
    endfunction

    function automatic deque_result_t apply_command(deque_cmd_t c);
        deque_result_t r;
        logic [tdd_pkg::HANDLE_W-1:0] e;
        logic [tdd_pkg::TYPE_W-1:0] ht, tt;
        bit took;
        r = '0;
        took = 1'b0;
        case (c.cmd)
            tdd_pkg::CMD_PUT_HEAD, tdd_pkg::CMD_PUT_TAIL:
                if (on_q[c.hnd])
                    r.err = tdd_pkg::ERR_QUEUED;
                else
                    attach(c.hnd, (c.dtype > NTYPE) ? tdd_pkg::TYPE_W'(NTYPE) : c.dtype,
                           c.cmd == tdd_pkg::CMD_PUT_HEAD);
            tdd_pkg::CMD_TAKE_HEAD, tdd_pkg::CMD_TAKE_TAIL:
                if (qsize == 0)
                    r.err = tdd_pkg::ERR_EMPTY;
                else
                begin
                    e = (c.cmd == tdd_pkg::CMD_TAKE_TAIL) ? prv[head_h] : head_h;
                    r.hnd = e;
                    r.ty = ety[e];
                    r.vld = 1'b1;
                    took = 1'b1;
                    detach(e);
                end
            tdd_pkg::CMD_REMOVE:
                if (!on_q[c.hnd])
                    r.err = tdd_pkg::ERR_NOT_QUEUED;
                else
                    detach(c.hnd);
            tdd_pkg::CMD_COUNT:
                if (c.dtype < NTYPE)
                    r.total = tdd_pkg::CNT_W'(tcount[c.dtype]);
                else
                    r.err = tdd_pkg::ERR_RANGE;
            default: ;
        endcase
        if (qsize == 0)
        begin
            ht = tdd_pkg::TYPE_W'(NTYPE);
            tt = tdd_pkg::TYPE_W'(NTYPE);
        end
        else
        begin
            ht = ety[head_h];
            tt = ety[prv[head_h]];
            if (c.cmd == tdd_pkg::CMD_PEEK)
            begin
                r.hnd = head_h;
                r.vld = 1'b1;
            end
        end
        if (!took)
            r.ty = ht;
        r.tail_ty = tt;
        r.hmatch = (qsize != 0) && (ht == c.dtype);
        r.tmatch = (qsize != 0) && (tt == c.dtype);
        r.occ = tdd_pkg::CNT_W'(qsize);
        return r;
    endfunction

    function automatic void push_cmd(int cmd, int h, int t);
        deque_cmd_t c;
        c.cmd = tdd_pkg::CMD_W'(cmd);
        c.hnd = tdd_pkg::HANDLE_W'(h);
        c.dtype = tdd_pkg::TYPE_W'(t);
        pending_cmds.push_back(c);
    endfunction

    // driver
    always @(posedge clk)
    begin
        deque_cmd_t c;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                c.cmd = command;
                c.hnd = handle;
                c.dtype = desc_type;
                expected_results.push_back(apply_command(c));
                in_gap = pick_gap();
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0 || hold_off || pending_cmds.size() == 0)
                begin
                    if (in_gap > 0)
                        in_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    c = pending_cmds.pop_front();
                    command <= c.cmd;
                    handle <= c.hnd;
                    desc_type <= c.dtype;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        deque_result_t w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected");
                    failures++;
                end
                else
                begin
                    w = expected_results.pop_front();
                    if (handle_out !== w.hnd)
                    begin
                        $error("handle_out exp %0d got %0d", w.hnd, handle_out);
                        failures++;
                    end
                    if (type_out !== w.ty)
                    begin
                        $error("type_out exp %0d got %0d", w.ty, type_out);
                        failures++;
                    end
                    if (tail_type !== w.tail_ty)
                    begin
                        $error("tail_type exp %0d got %0d", w.tail_ty, tail_type);
                        failures++;
                    end
                    if (head_match !== w.hmatch)
                    begin
                        $error("head_match exp %0d got %0d", w.hmatch, head_match);
                        failures++;
                    end
                    if (tail_match !== w.tmatch)
                    begin
                        $error("tail_match exp %0d got %0d", w.tmatch, tail_match);
                        failures++;
                    end
                    if (valid_out !== w.vld)
                    begin
                        $error("valid_out exp %0d got %0d", w.vld, valid_out);
                        failures++;
                    end
                    if (occupancy !== w.occ)
                    begin
                        $error("occupancy exp %0d got %0d", w.occ, occupancy);
                        failures++;
                    end
                    if (type_total !== w.total)
                    begin
                        $error("type_total exp %0d got %0d", w.total, type_total);
                        failures++;
                    end
                    if (error_code !== w.err)
                    begin
                        $error("error_code exp %0d got %0d", w.err, error_code);
                        failures++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                out_stall <= (out_gap > 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int r, h, k;
        foreach (on_q[i])
            on_q[i] = 1'b0;
        foreach (tcount[i])
            tcount[i] = 0;
        head_h = '0;
        qsize = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        push_cmd(tdd_pkg::CMD_TAKE_HEAD, 0, 0);
        push_cmd(tdd_pkg::CMD_TAKE_TAIL, 63, 7);
        push_cmd(tdd_pkg::CMD_PEEK, 0, 4);
        push_cmd(tdd_pkg::CMD_REMOVE, 5, 0);
        push_cmd(tdd_pkg::CMD_PUT_TAIL, 0, 0);
        push_cmd(tdd_pkg::CMD_PUT_HEAD, 63, 3);
        push_cmd(tdd_pkg::CMD_PUT_TAIL, 21, 7);
        push_cmd(tdd_pkg::CMD_PUT_HEAD, 42, 4);
        push_cmd(tdd_pkg::CMD_PUT_TAIL, 63, 1);
        push_cmd(tdd_pkg::CMD_PEEK, 0, 4);
        push_cmd(tdd_pkg::CMD_COUNT, 0, 0);
        push_cmd(tdd_pkg::CMD_COUNT, 0, 3);
        push_cmd(tdd_pkg::CMD_COUNT, 0, 4);
        push_cmd(tdd_pkg::CMD_COUNT, 0, 7);
        push_cmd(CMD_UNUSED, 33, 2);
        push_cmd(tdd_pkg::CMD_REMOVE, 0, 0);
        push_cmd(tdd_pkg::CMD_REMOVE, 0, 0);
        push_cmd(tdd_pkg::CMD_TAKE_TAIL, 0, 4);
        push_cmd(tdd_pkg::CMD_TAKE_HEAD, 0, 3);
        push_cmd(tdd_pkg::CMD_PEEK, 0, 4);
        push_cmd(tdd_pkg::CMD_TAKE_HEAD, 0, 0);
        push_cmd(tdd_pkg::CMD_TAKE_HEAD, 0, 0);

        // random: bias puts so the ring fills well and sometimes completely
        for (k = 0; k < 470; k++)
        begin
            if (k == 200)
            begin
                for (h = 0; h < POOL; h++)
                    push_cmd(pick_put(), h, $urandom_range(0, 7));
            end
            r = $urandom_range(0, 99);
            h = (r % 3 == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
            if (r < 35)
                push_cmd(pick_put(), h, $urandom_range(0, 7));
            else if (r < 60)
                push_cmd(pick_take(), h, $urandom_range(0, 7));
            else if (r < 75)
                push_cmd(tdd_pkg::CMD_REMOVE, h, $urandom_range(0, 7));
            else if (r < 88)
                push_cmd(tdd_pkg::CMD_PEEK, h, $urandom_range(0, 7));
            else if (r < 98)
                push_cmd(tdd_pkg::CMD_COUNT, h, $urandom_range(0, 7));
            else
                push_cmd(CMD_UNUSED, h, $urandom_range(0, 7));
            if (k == 300)
            begin
                wait (pending_cmds.size() == 0);
                hold_off = 1'b1;
                wait (expected_results.size() == 0 && !in_valid);
                hold_off = 1'b0;
            end
        end

        wait (pending_cmds.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
